// ===== design/bfm_pkg.sv =====
package bfm_pkg;

  localparam int DEF_MAX_NODES   = 64;
  localparam int DEF_WEIGHT_BITS = 32;

  // node indexes on the ports and in the matrix address
  localparam int IDX_BITS    = 6;
  localparam int CMP_BITS    = IDX_BITS + 1;
  localparam int NCOUNT_BITS = 7;

  // APB register map
  localparam int APB_DATA_BITS = 32;
  localparam int ADDR_BITS     = 3;
  localparam int REG_IDX_BITS  = ADDR_BITS - 2;

  localparam logic [REG_IDX_BITS-1:0] REG_NODE_COUNT  = REG_IDX_BITS'(0);
  localparam logic [REG_IDX_BITS-1:0] REG_SOURCE_NODE = REG_IDX_BITS'(1);

  localparam logic [NCOUNT_BITS-1:0] NODE_COUNT_RST = NCOUNT_BITS'(1);

  typedef struct packed {
    logic [NCOUNT_BITS-1:0] node_count;
    logic [IDX_BITS-1:0]    source_node;
  } bfm_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_LOADV,
    ST_RELAX,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } bfm_state_t;

endpackage

// ===== design/bfm_if.sv =====
interface bfm_in_if #(
  parameter int WEIGHT_BITS = bfm_pkg::DEF_WEIGHT_BITS
);
  import bfm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [IDX_BITS-1:0]           row;
  logic [IDX_BITS-1:0]           col;
  logic signed [WEIGHT_BITS-1:0] weight;
  logic                          no_edge;
  logic                          last;

  modport source (output valid, row, col, weight, no_edge, last, input ready);
  modport sink (input valid, row, col, weight, no_edge, last, output ready);

endinterface

interface bfm_out_if #(
  parameter int WEIGHT_BITS = bfm_pkg::DEF_WEIGHT_BITS
);
  import bfm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [IDX_BITS-1:0]           node;
  logic signed [WEIGHT_BITS-1:0] distance;
  logic                          unreachable;
  logic [IDX_BITS-1:0]           predecessor;
  logic                          last_node;

  modport source (output valid, node, distance, unreachable, predecessor, last_node,
                  input ready);
  modport sink (input valid, node, distance, unreachable, predecessor, last_node,
                output ready);

endinterface

// ===== design/bfm_relax.sv =====
module bfm_relax #(
  parameter int WEIGHT_BITS = bfm_pkg::DEF_WEIGHT_BITS
) (
  input  logic [WEIGHT_BITS:0]         via_dist,
  input  logic [WEIGHT_BITS:0]         wgt,
  input  logic [WEIGHT_BITS:0]         cur_dist,
  input  logic [bfm_pkg::IDX_BITS-1:0] cur_pred,
  input  logic [bfm_pkg::IDX_BITS-1:0] via_idx,
  output logic [WEIGHT_BITS:0]         nxt_dist,
  output logic [bfm_pkg::IDX_BITS-1:0] nxt_pred
);
  import bfm_pkg::*;

  localparam int SUM_BITS = WEIGHT_BITS + 1;
  // saturation bounds: largest value minus one, most negative value
  localparam logic signed [SUM_BITS-1:0] SAT_HI = {2'b00, {(WEIGHT_BITS-2){1'b1}}, 1'b0};
  localparam logic signed [SUM_BITS-1:0] SAT_LO = {2'b11, {(WEIGHT_BITS-1){1'b0}}};

  logic signed [SUM_BITS-1:0]    sum;
  logic signed [WEIGHT_BITS-1:0] sat;
  logic signed [WEIGHT_BITS-1:0] cur_val;
  logic                          take;

  assign sum = $signed({via_dist[WEIGHT_BITS-1], via_dist[WEIGHT_BITS-1:0]})
             + $signed({wgt[WEIGHT_BITS-1], wgt[WEIGHT_BITS-1:0]});

  always_comb begin
    if (sum > SAT_HI) begin
      sat = SAT_HI[WEIGHT_BITS-1:0];
    end else if (sum < SAT_LO) begin
      sat = SAT_LO[WEIGHT_BITS-1:0];
    end else begin
      sat = sum[WEIGHT_BITS-1:0];
    end
  end

  assign cur_val = cur_dist[WEIGHT_BITS-1:0];

  // top bit of a cell is the infinity mark
  assign take = !via_dist[WEIGHT_BITS] && !wgt[WEIGHT_BITS]
             && (cur_dist[WEIGHT_BITS] || (cur_val > sat));

  assign nxt_dist = take ? {1'b0, sat} : cur_dist;
  assign nxt_pred = take ? via_idx : cur_pred;

endmodule

// ===== design/bfm_cfg.sv =====
module bfm_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bfm_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [bfm_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [bfm_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready,
  output bfm_pkg::bfm_cfg_t                 cfg
);
  import bfm_pkg::*;

  logic [NCOUNT_BITS-1:0]  node_count_r;
  logic [IDX_BITS-1:0]     source_node_r;
  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                    wr_en;

  assign reg_idx = paddr[ADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r  <= NODE_COUNT_RST;
      source_node_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NODE_COUNT:  node_count_r  <= pwdata[NCOUNT_BITS-1:0];
        REG_SOURCE_NODE: source_node_r <= pwdata[IDX_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NODE_COUNT:  prdata = APB_DATA_BITS'(node_count_r);
      REG_SOURCE_NODE: prdata = APB_DATA_BITS'(source_node_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.node_count  = node_count_r;
  assign cfg.source_node = source_node_r;

endmodule

// ===== design/bfm_seq.sv =====
module bfm_seq #(
  parameter int MAX_NODES   = bfm_pkg::DEF_MAX_NODES,
  parameter int WEIGHT_BITS = bfm_pkg::DEF_WEIGHT_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bfm_pkg::bfm_cfg_t cfg,
  bfm_in_if.sink            in_ch,
  bfm_out_if.source         out_ch
);
  import bfm_pkg::*;

  localparam int NODE_BITS  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_BITS   = $clog2(MAX_NODES + 1);
  localparam int CELL_BITS  = WEIGHT_BITS + 1;
  localparam int WADDR_BITS = 2 * IDX_BITS;
  localparam int WDEPTH     = 1 << WADDR_BITS;

  localparam logic [CNT_BITS-1:0]    CNT_ONE   = CNT_BITS'(1);
  localparam logic [CNT_BITS-1:0]    CNT_THREE = CNT_BITS'(3);
  localparam logic [CNT_BITS-1:0]    CNT_MAX   = CNT_BITS'(MAX_NODES);
  localparam logic [NCOUNT_BITS-1:0] NC_MAX    = NCOUNT_BITS'(MAX_NODES);
  localparam logic [WEIGHT_BITS-1:0] W_MAXV    = {1'b0, {(WEIGHT_BITS-1){1'b1}}};

  function automatic logic is_src(input logic [CNT_BITS-1:0] idx,
                                  input logic [IDX_BITS-1:0] s);
    return CMP_BITS'(idx) == CMP_BITS'(s);
  endfunction

  bfm_state_t state_r, state_nxt;

  logic [CNT_BITS-1:0] n_r, v_r, u_r, round_r;
  logic [IDX_BITS-1:0] src_r;
  logic [CNT_BITS-1:0] active_n, uc, vd, v_step, round_step;
  logic                v_end, pass_done, v_is_src;

  logic in_rdy, in_acc, out_acc;
  logic [CELL_BITS-1:0] in_cell;
  logic                 in_inf;

  // weight store: {no-edge, weight}, row-major by (from, to)
  logic [CELL_BITS-1:0]  wmem [WDEPTH];
  logic [WADDR_BITS-1:0] w_raddr;
  logic [CELL_BITS-1:0]  wrd_r;

  // distance and predecessor stores, one read and one write port
  logic [CELL_BITS-1:0] dmem [MAX_NODES];
  logic [IDX_BITS-1:0]  pmem [MAX_NODES];
  logic [NODE_BITS-1:0] d_raddr, d_waddr;
  logic                 d_we;
  logic [CELL_BITS-1:0] d_wdata, drd_r;
  logic [IDX_BITS-1:0]  p_wdata, prd_r;

  logic [CELL_BITS-1:0] cur_r, cur_nxt, via_dist;
  logic [IDX_BITS-1:0]  curp_r, curp_nxt;

  logic                          out_valid_r;
  logic [IDX_BITS-1:0]           out_node_r, out_pred_r;
  logic signed [WEIGHT_BITS-1:0] out_dist_r;
  logic                          out_unr_r, out_last_r;

  assign in_rdy  = (state_r == ST_IDLE);
  assign in_acc  = in_ch.valid && in_rdy;
  assign out_acc = out_valid_r && out_ch.ready;

  assign in_inf  = in_ch.no_edge || (in_ch.weight == W_MAXV);
  assign in_cell = in_inf ? {1'b1, {WEIGHT_BITS{1'b0}}} : {1'b0, in_ch.weight};

  always_comb begin
    if (cfg.node_count == '0) begin
      active_n = CNT_ONE;
    end else if (cfg.node_count > NC_MAX) begin
      active_n = CNT_MAX;
    end else begin
      active_n = CNT_BITS'(cfg.node_count);
    end
  end

  // uc: via node of the step in the compare stage, vd: node written during init
  assign uc         = u_r - CNT_ONE;
  assign vd         = v_r - CNT_ONE;
  assign v_is_src   = is_src(v_r, src_r);
  assign v_end      = (v_r == n_r - CNT_ONE);
  assign pass_done  = v_end && (round_r == n_r - CNT_THREE);
  assign v_step     = v_end ? '0 : v_r + CNT_ONE;
  assign round_step = v_end ? round_r + CNT_ONE : round_r;

  // in-place relaxation: target's own distance comes from the working register
  assign via_dist = (uc == v_r) ? cur_r : drd_r;

  bfm_relax #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_relax (
    .via_dist (via_dist),
    .wgt      (wrd_r),
    .cur_dist (cur_r),
    .cur_pred (curp_r),
    .via_idx  (IDX_BITS'(uc)),
    .nxt_dist (cur_nxt),
    .nxt_pred (curp_nxt)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      wmem[{in_ch.row, in_ch.col}] <= in_cell;
    end
    wrd_r <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dmem[d_waddr] <= d_wdata;
      pmem[d_waddr] <= p_wdata;
    end
    drd_r <= dmem[d_raddr];
    prd_r <= pmem[d_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_ch.last) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        if (v_r == n_r) state_nxt = (n_r < CNT_THREE) ? ST_EMIT_RD : ST_LOADV;
      end
      ST_LOADV: begin
        if (!v_is_src) begin
          state_nxt = ST_RELAX;
        end else if (pass_done) begin
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_RELAX: begin
        if (u_r == n_r - CNT_ONE) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = pass_done ? ST_EMIT_RD : ST_LOADV;
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        state_nxt = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_acc) state_nxt = out_last_r ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory addressing and write strobes
  always_comb begin
    w_raddr = {IDX_BITS'(u_r), IDX_BITS'(v_r)};
    d_raddr = v_r[NODE_BITS-1:0];
    d_waddr = v_r[NODE_BITS-1:0];
    d_we    = 1'b0;
    d_wdata = cur_nxt;
    p_wdata = curp_nxt;
    unique case (state_r)
      ST_INIT: begin
        w_raddr = {src_r, IDX_BITS'(v_r)};
        d_we    = (v_r != '0);
        d_waddr = vd[NODE_BITS-1:0];
        d_wdata = is_src(vd, src_r) ? '0 : wrd_r;
        p_wdata = src_r;
      end
      ST_RELAX: begin
        d_raddr = u_r[NODE_BITS-1:0];
      end
      ST_DRAIN: begin
        d_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= CNT_ONE;
      src_r       <= '0;
      v_r         <= '0;
      u_r         <= '0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (in_acc && in_ch.last) begin
            n_r     <= active_n;
            src_r   <= cfg.source_node;
            v_r     <= '0;
            round_r <= '0;
          end
        end
        ST_INIT: begin
          v_r <= (v_r == n_r) ? '0 : v_r + CNT_ONE;
        end
        ST_LOADV: begin
          u_r <= '0;
          if (v_is_src) begin
            v_r     <= v_step;
            round_r <= round_step;
          end
        end
        ST_RELAX: begin
          u_r <= u_r + CNT_ONE;
        end
        ST_DRAIN: begin
          v_r     <= v_step;
          round_r <= round_step;
        end
        ST_EMIT_LD: begin
          out_valid_r <= 1'b1;
        end
        ST_EMIT_WAIT: begin
          if (out_acc) begin
            out_valid_r <= 1'b0;
            v_r         <= v_r + CNT_ONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RELAX) begin
      if (u_r == '0) begin
        cur_r  <= drd_r;
        curp_r <= prd_r;
      end else begin
        cur_r  <= cur_nxt;
        curp_r <= curp_nxt;
      end
    end
    if (state_r == ST_EMIT_LD) begin
      out_node_r <= IDX_BITS'(v_r);
      out_dist_r <= drd_r[WEIGHT_BITS] ? '0 : drd_r[WEIGHT_BITS-1:0];
      out_unr_r  <= drd_r[WEIGHT_BITS];
      out_pred_r <= prd_r;
      out_last_r <= v_end;
    end
  end

  assign in_ch.ready        = in_rdy;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.node        = out_node_r;
  assign out_ch.distance    = out_dist_r;
  assign out_ch.unreachable = out_unr_r;
  assign out_ch.predecessor = out_pred_r;
  assign out_ch.last_node   = out_last_r;

endmodule

// ===== design/bellman_ford_matrix_shortest_path.sv =====
// Channel   Dir  Interface            Transaction
// in_ch     in   bfm_in_if.sink       one matrix entry (row, col, weight, no_edge, last)
// out_ch    out  bfm_out_if.source    one node result (node, distance, unreachable,
//                                     predecessor, last_node)
// APB       in   psel..pready         reg 0 node_count @0x0, reg 1 source_node @0x4
//
// Entries load at one per cycle while idle. A last entry starts a run: an init pass,
// then n-2 rounds (none below three nodes), each relaxing every node but an in-range
// source, one relaxation step per cycle through the shared add/compare unit and the
// store ports. Results then go out one node at a time, each held until out_ch takes
// it; in_ch is held off from the last entry until the final result transaction. Reset
// is synchronous, rst_n low; the matrix and distance stores are not cleared.
module bellman_ford_matrix_shortest_path #(
  parameter int MAX_NODES   = bfm_pkg::DEF_MAX_NODES,
  parameter int WEIGHT_BITS = bfm_pkg::DEF_WEIGHT_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bfm_in_if.sink                            in_ch,
  bfm_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bfm_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [bfm_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [bfm_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import bfm_pkg::*;

  bfm_cfg_t cfg;

  bfm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bfm_seq #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ===== bench/testbench.sv =====
module testbench;
  import bfm_pkg::*;

  localparam int WB = DEF_WEIGHT_BITS;
  localparam longint LEN_MAX = (64'sd1 <<< (WB - 1)) - 1;
  localparam longint LEN_MIN = -(64'sd1 <<< (WB - 1));
  localparam logic signed [WB-1:0] W_TOP = WB'(LEN_MAX);
  localparam logic signed [WB-1:0] W_LOW = WB'(LEN_MIN);
  localparam int RANDOM_ITEMS = 460;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic [IDX_BITS-1:0] node;
    logic signed [WB-1:0] distance;
    logic                 unreachable;
    logic [IDX_BITS-1:0] predecessor;
    logic                 last_node;
  } node_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;

  bfm_in_if  #(.WEIGHT_BITS(WB)) in_if ();
  bfm_out_if #(.WEIGHT_BITS(WB)) out_if ();

  bellman_ford_matrix_shortest_path #(
    .MAX_NODES  (DEF_MAX_NODES),
    .WEIGHT_BITS(WB)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #1 clk = ~clk;

  // matrix and register copies
  bit     edge_absent [4096];
  longint edge_len    [4096];
  bit     edge_loaded [4096];
  logic [NCOUNT_BITS-1:0] node_count_reg = NODE_COUNT_RST;
  logic [IDX_BITS-1:0]    source_reg = '0;

  node_result_t expected_results [$];
  int failures = 0;
  int cycle_count = 0;
  bit in_burst;
  bit out_burst;
  int out_stall = 0;

  function automatic int pick_gap(bit burst);
    int roll;
    if (burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic int active_count(logic [NCOUNT_BITS-1:0] count);
    if (count == 0) return 1;
    if (count > DEF_MAX_NODES) return DEF_MAX_NODES;
    return int'(count);
  endfunction

  function automatic logic signed [WB-1:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return W_TOP;
          1: return W_TOP - 1;
          2: return W_LOW;
          default: return -1;
        endcase
      end
      default: return WB'($urandom_range(0, 120)) - 40;
    endcase
  endfunction

  function automatic void store_entry(logic [IDX_BITS-1:0] r, logic [IDX_BITS-1:0] c,
                                      logic signed [WB-1:0] w, logic ne);
    int idx;
    idx = int'({r, c});
    edge_absent[idx] = ne || (w == W_TOP);
    edge_len[idx]    = edge_absent[idx] ? 0 : longint'(w);
    edge_loaded[idx] = 1'b1;
  endfunction

  // full relaxation over the current matrix, then one expected result per node
  function automatic void predict_paths();
    bit     reach_none [64];
    longint reach_len  [64];
    logic [IDX_BITS-1:0] reach_via [64];
    longint total;
    node_result_t res;
    int n;
    int s;
    n = active_count(node_count_reg);
    s = int'(source_reg);
    for (int v = 0; v < n; v++) begin
      reach_none[v] = edge_absent[s * 64 + v];
      reach_len[v]  = edge_len[s * 64 + v];
      reach_via[v]  = source_reg;
    end
    if (s < n) begin
      reach_none[s] = 1'b0;
      reach_len[s]  = 0;
    end
    for (int r = 0; r + 2 < n; r++) begin
      for (int v = 0; v < n; v++) begin
        if (v == s) continue;
        for (int u = 0; u < n; u++) begin
          if (reach_none[u] || edge_absent[u * 64 + v]) continue;
          total = reach_len[u] + edge_len[u * 64 + v];
          if (total > LEN_MAX - 1) total = LEN_MAX - 1;
          else if (total < LEN_MIN) total = LEN_MIN;
          if (reach_none[v] || reach_len[v] > total) begin
            reach_none[v] = 1'b0;
            reach_len[v]  = total;
            reach_via[v]  = IDX_BITS'(u);
          end
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      res.node        = IDX_BITS'(k);
      res.distance    = reach_none[k] ? '0 : WB'(reach_len[k]);
      res.unreachable = reach_none[k];
      res.predecessor = reach_via[k];
      res.last_node   = (k == n - 1);
      expected_results = {expected_results, res};
    end
  endfunction

  // valid stays high after acceptance so back-to-back transactions need no toggle;
  // anything else that lets time pass calls wait_drain first
  task automatic send_entry(input logic [IDX_BITS-1:0] r, input logic [IDX_BITS-1:0] c,
                            input logic signed [WB-1:0] w, input logic ne, input logic lst);
    int gap;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = pick_gap(in_burst);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.row     <= r;
    in_if.col     <= c;
    in_if.weight  <= w;
    in_if.no_edge <= ne;
    in_if.last    <= lst;
    do @(posedge clk); while (!in_if.ready);
    store_entry(r, c, w, ne);
    if (lst) predict_paths();
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_BITS-1:0] index,
                           input logic [APB_DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (index == REG_NODE_COUNT) node_count_reg = value[NCOUNT_BITS-1:0];
    else source_reg = value[IDX_BITS-1:0];
    @(posedge clk);
  endtask

  task automatic set_graph(input int count, input int src);
    wait_drain();
    write_reg(REG_NODE_COUNT, count);
    write_reg(REG_SOURCE_NODE, src);
  endtask

  task automatic test_reset_values();
    send_entry(0, 0, rand_weight(), 1'($urandom_range(0, 1)), 1'b1);
    wait_drain();
  endtask

  task automatic test_zero_count();
    wait_drain();
    write_reg(REG_NODE_COUNT, 0);
    send_entry(0, 0, rand_weight(), 1'($urandom_range(0, 1)), 1'b1);
    wait_drain();
  endtask

  task automatic test_two_nodes();
    set_graph(2, 1);
    send_entry(0, 0, 7, 1'b0, 1'b0);
    send_entry(0, 1, 3, 1'b0, 1'b0);
    send_entry(1, 1, W_LOW, 1'b0, 1'b0);
    send_entry(1, 0, -5, 1'b0, 1'b1);
    wait_drain();
  endtask

  task automatic test_saturation();
    set_graph(3, 0);
    send_entry(0, 0, 0, 1'b0, 1'b0);
    send_entry(0, 1, W_TOP - 1, 1'b0, 1'b0);
    send_entry(0, 2, $urandom, 1'b1, 1'b0);
    send_entry(1, 0, $urandom, 1'b1, 1'b0);
    send_entry(1, 1, 0, 1'b0, 1'b0);
    send_entry(1, 2, W_TOP - 1, 1'b0, 1'b0);
    send_entry(2, 0, $urandom, 1'b1, 1'b0);
    send_entry(2, 1, $urandom, 1'b1, 1'b0);
    send_entry(2, 2, 0, 1'b0, 1'b1);
    // negative clamp
    send_entry(0, 1, W_LOW, 1'b0, 1'b0);
    send_entry(1, 2, W_LOW, 1'b0, 1'b1);
    // max weight means no edge: node 2 loses every path
    send_entry(1, 2, W_TOP, 1'b0, 1'b0);
    send_entry(0, 2, W_TOP, 1'b0, 1'b1);
    wait_drain();
  endtask

  task automatic test_source_outside();
    set_graph(3, 63);
    send_entry(63, 0, 4, 1'b0, 1'b0);
    send_entry(63, 1, $urandom, 1'b1, 1'b0);
    send_entry(63, 2, -9, 1'b0, 1'b1);
    wait_drain();
  endtask

  task automatic test_random_graphs();
    int sent;
    int count;
    int n;
    int src;
    int j;
    int t;
    int jobs [$];
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: count = 0;
        1: count = 1;
        2, 3, 4: count = $urandom_range(7, 12);
        default: count = $urandom_range(2, 6);
      endcase
      n = active_count(NCOUNT_BITS'(count));
      src = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
      set_graph(count, src);
      repeat ($urandom_range(1, 3)) begin
        jobs.delete();
        // every entry the run will read must be loaded first
        for (int u = 0; u < n; u++)
          for (int v = 0; v < n; v++)
            if (!edge_loaded[u * 64 + v]) jobs = {jobs, u * 64 + v};
        for (int v = 0; v < n; v++)
          if (!edge_loaded[src * 64 + v]) jobs = {jobs, src * 64 + v};
        repeat ($urandom_range(0, n))
          jobs = {jobs, int'($urandom_range(0, n - 1) * 64 + $urandom_range(0, n - 1))};
        repeat ($urandom_range(0, 2)) jobs = {jobs, int'($urandom_range(0, 4095))};
        if (jobs.size() == 0) jobs = {jobs, int'($urandom_range(0, n - 1) * 64)};
        for (int i = jobs.size() - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = jobs[i];
          jobs[i] = jobs[j];
          jobs[j] = t;
        end
        for (int i = 0; i < jobs.size(); i++)
          send_entry(IDX_BITS'(jobs[i] >> 6), IDX_BITS'(jobs[i]), rand_weight(),
                     $urandom_range(0, 3) == 0, i == jobs.size() - 1);
        sent += jobs.size();
        if ($urandom_range(0, 7) == 0) wait_drain();
      end
    end
    wait_drain();
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : check_results
    node_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction for node %0d with none expected", out_if.node);
        failures++;
      end else begin
        want = expected_results.pop_front();
        check_field("node", 64'(want.node), 64'(out_if.node));
        check_field("distance", 64'(want.distance), 64'(out_if.distance));
        check_field("unreachable", 64'(want.unreachable), 64'(out_if.unreachable));
        check_field("predecessor", 64'(want.predecessor), 64'(out_if.predecessor));
        check_field("last_node", 64'(want.last_node), 64'(out_if.last_node));
      end
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 127) == 0) out_burst <= !out_burst;
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_if.ready <= 1'b0;
    end else if (!out_burst && $urandom_range(0, 5) == 0) begin
      out_stall <= pick_gap(1'b0);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.row     <= '0;
    in_if.col     <= '0;
    in_if.weight  <= '0;
    in_if.no_edge <= 1'b0;
    in_if.last    <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_zero_count();
    test_two_nodes();
    test_saturation();
    test_source_outside();
    test_random_graphs();

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== bellman_ford_matrix_shortest_path.f =====
design/bfm_pkg.sv
design/bfm_if.sv
design/bfm_relax.sv
design/bfm_cfg.sv
design/bfm_seq.sv
design/bellman_ford_matrix_shortest_path.sv
bench/testbench.sv
